// ===== rtl/redmean_color_distance_defines.svh =====
// ---------------------------------------------------------------------------
// Redmean color distance assertion macros
// Shared concurrent-check macros; empty when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef REDMEAN_COLOR_DISTANCE_DEFINES_SVH
`define REDMEAN_COLOR_DISTANCE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication.
`define RCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("redmean_color_distance: check failed");
// Next-cycle implication.
`define RCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("redmean_color_distance: check failed");
`else
`define RCD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RCD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/rcd_pkg.sv =====
// ---------------------------------------------------------------------------
// Redmean color distance package
// Widths and pipeline constants for the redmean distance datapath.
// ---------------------------------------------------------------------------
package rcd_pkg;

  localparam int CHAN_W   = 8;               // color channel
  localparam int SQ_W     = 2 * CHAN_W;      // squared channel difference
  localparam int WGT_W    = 10;              // red/blue weight, 512..767
  localparam int PROD_W   = 26;              // weight times square
  localparam int SUM_W    = 28;              // weighted sum S
  localparam int DIST_W   = 14;              // floor(sqrt(S))
  localparam int TRL_W    = SUM_W + 1;       // square root trial value

  localparam logic [WGT_W-1:0] RED_BASE  = 10'd512;
  localparam logic [WGT_W-1:0] BLUE_BASE = 10'd767;
  localparam int GREEN_SHIFT = 10;           // green weight 1024

  localparam int SQ_STAGES = DIST_W / 2;     // two root bits per stage
  localparam int LATENCY   = 4 + SQ_STAGES;  // start to out_valid
  localparam logic [DIST_W-1:0] DIST_MAX = 14'd12288;

endpackage

// ===== rtl/redmean_color_distance.sv =====
// ---------------------------------------------------------------------------
// Redmean color distance
// Pipelined redmean perceptual distance between two RGB colors, Q.4 result.
// ---------------------------------------------------------------------------
// A transaction is accepted on every clock edge with start high; busy is
// always low, so a new color pair may enter each cycle. Each result appears
// on out_distance_q4 with out_valid high for exactly one cycle, in acceptance
// order. The receiver cannot stall the block. The depth is set by the
// datapath: one stage for the channel differences and red mean, one for
// the squares and weights, one for the weight multiplies, one for the sum,
// and seven square root stages that each settle two bits of the 14-bit
// root. The result is floor(sqrt((512+rmean)*dR^2 + 1024*dG^2 +
// (767-rmean)*dB^2)), which is the redmean distance with four fractional
// bits, truncated.
// ---------------------------------------------------------------------------
`include "redmean_color_distance_defines.svh"

module redmean_color_distance (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [rcd_pkg::CHAN_W-1:0]   in_tile_red,
  input  logic [rcd_pkg::CHAN_W-1:0]   in_tile_green,
  input  logic [rcd_pkg::CHAN_W-1:0]   in_tile_blue,
  input  logic [rcd_pkg::CHAN_W-1:0]   in_image_red,
  input  logic [rcd_pkg::CHAN_W-1:0]   in_image_green,
  input  logic [rcd_pkg::CHAN_W-1:0]   in_image_blue,
  output logic                         out_valid,
  output logic [rcd_pkg::DIST_W-1:0]   out_distance_q4
);
  import rcd_pkg::*;

  // Never hold off the sender: the pipeline advances every cycle.
  assign busy = 1'b0;

  // -------------------------------------------------------------------------
  // Stage 1: absolute channel differences and truncated red mean
  // -------------------------------------------------------------------------
  logic              s1_vld_r;
  logic [CHAN_W-1:0] s1_dr_r, s1_dg_r, s1_db_r, s1_rmean_r;
  logic [CHAN_W-1:0] s1_dr_nxt, s1_dg_nxt, s1_db_nxt, s1_rmean_nxt;
  logic [CHAN_W:0]   s1_rsum;

  always_comb begin
    s1_dr_nxt = (in_image_red >= in_tile_red) ? (in_image_red - in_tile_red)
                                              : (in_tile_red - in_image_red);
    s1_dg_nxt = (in_image_green >= in_tile_green) ? (in_image_green - in_tile_green)
                                                  : (in_tile_green - in_image_green);
    s1_db_nxt = (in_image_blue >= in_tile_blue) ? (in_image_blue - in_tile_blue)
                                                : (in_tile_blue - in_image_blue);
    s1_rsum      = {1'b0, in_image_red} + {1'b0, in_tile_red};
    s1_rmean_nxt = s1_rsum[CHAN_W:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s1_dr_r    <= s1_dr_nxt;
    s1_dg_r    <= s1_dg_nxt;
    s1_db_r    <= s1_db_nxt;
    s1_rmean_r <= s1_rmean_nxt;
  end

  // -------------------------------------------------------------------------
  // Stage 2: squares of the differences, red and blue weights
  // -------------------------------------------------------------------------
  logic             s2_vld_r;
  logic [SQ_W-1:0]  s2_r2_r, s2_g2_r, s2_b2_r;
  logic [WGT_W-1:0] s2_wr_r, s2_wb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r2_r <= SQ_W'(s1_dr_r) * SQ_W'(s1_dr_r);
    s2_g2_r <= SQ_W'(s1_dg_r) * SQ_W'(s1_dg_r);
    s2_b2_r <= SQ_W'(s1_db_r) * SQ_W'(s1_db_r);
    s2_wr_r <= RED_BASE + WGT_W'(s1_rmean_r);
    s2_wb_r <= BLUE_BASE - WGT_W'(s1_rmean_r);
  end

  // -------------------------------------------------------------------------
  // Stage 3: weighted terms
  // -------------------------------------------------------------------------
  logic              s3_vld_r;
  logic [PROD_W-1:0] s3_rt_r, s3_gt_r, s3_bt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_rt_r <= PROD_W'(s2_wr_r) * PROD_W'(s2_r2_r);
    s3_bt_r <= PROD_W'(s2_wb_r) * PROD_W'(s2_b2_r);
    s3_gt_r <= PROD_W'(s2_g2_r) << GREEN_SHIFT;
  end

  // -------------------------------------------------------------------------
  // Stage 4 and square root pipeline. Entry 0 holds the sum S; entry k holds
  // the remainder and partial root after k root stages.
  // -------------------------------------------------------------------------
  logic              sq_vld_r  [0:SQ_STAGES];
  logic [SUM_W-1:0]  sq_rem_r  [0:SQ_STAGES];
  logic [DIST_W-1:0] sq_root_r [0:SQ_STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else begin
      sq_vld_r[0] <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_rem_r[0]  <= SUM_W'(s3_rt_r) + SUM_W'(s3_gt_r) + SUM_W'(s3_bt_r);
    sq_root_r[0] <= '0;
  end

  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    localparam int Hi = DIST_W - 1 - 2 * g;  // upper root bit of this stage
    localparam int Lo = Hi - 1;              // lower root bit of this stage

    logic [TRL_W-1:0]  trial_hi, trial_lo, rem_mid, rem_in;
    logic [DIST_W-1:0] root_mid, root_nxt;
    logic [SUM_W-1:0]  rem_nxt;

    // Try each root bit: keep it if (root + 2^i)^2 still fits under S.
    always_comb begin
      rem_in   = TRL_W'(sq_rem_r[g]);
      trial_hi = (TRL_W'(sq_root_r[g]) << (Hi + 1)) + (TRL_W'(1) << (2 * Hi));
      if (rem_in >= trial_hi) begin
        rem_mid  = rem_in - trial_hi;
        root_mid = sq_root_r[g] | (DIST_W'(1) << Hi);
      end else begin
        rem_mid  = rem_in;
        root_mid = sq_root_r[g];
      end
      trial_lo = (TRL_W'(root_mid) << (Lo + 1)) + (TRL_W'(1) << (2 * Lo));
      if (rem_mid >= trial_lo) begin
        rem_nxt  = SUM_W'(rem_mid - trial_lo);
        root_nxt = root_mid | (DIST_W'(1) << Lo);
      end else begin
        rem_nxt  = SUM_W'(rem_mid);
        root_nxt = root_mid;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[g+1] <= 1'b0;
      end else begin
        sq_vld_r[g+1] <= sq_vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      sq_rem_r[g+1]  <= rem_nxt;
      sq_root_r[g+1] <= root_nxt;
    end
  end

  // Drive the result strobe straight from the last root stage.
  assign out_valid       = sq_vld_r[SQ_STAGES];
  assign out_distance_q4 = sq_root_r[SQ_STAGES];

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------
  `RCD_ASSERT_IMPL(a_fixed_latency, clk, rst_n, out_valid, $past(start, LATENCY))
  `RCD_ASSERT_IMPL(a_root_range, clk, rst_n, out_valid, out_distance_q4 <= DIST_MAX)
  `RCD_ASSERT_NEXT(a_sum_to_root, clk, rst_n, s3_vld_r, sq_vld_r[0])

endmodule
